// ===== hdl/lcpd_pkg.sv =====
// shared constants and types for the lattice code point decoder
// no dependencies; imported by lcpd_axis and lattice_code_point_decoder
package lcpd_pkg;

    // default modulus exponent, q = 2^LOG_Q
    localparam int LOG_Q_DEF = 13;

    // raw coordinate width and decoded result width
    localparam int COORD_W = 16;
    localparam int OUT_W   = 4;

    // stream data widths, padded to whole bytes
    localparam int IN_TDATA_W  = 2 * COORD_W;
    localparam int OUT_TDATA_W = 8;

    // load enables for the two stages inside a per-coordinate unit
    typedef struct packed {
        logic s1;
        logic s2;
    } t_axis_en;

endpackage

// ===== hdl/lattice_code_point_decoder.sv =====
// lattice code point decoder: streams one two-coordinate point per cycle to 4 bits
// depends on lcpd_pkg and lcpd_axis
//
// usage
//   input stream s_axis: tdata carries coord_x in bits 15:0 and coord_y in
//   bits 31:16; only the low LOG_Q bits of each coordinate are used.
//   output stream m_axis: tdata bits 3:0 carry the decoded bits (outer x,
//   outer y, inner x, inner y from bit 3 down), bits 7:4 are zero.
//   every accepted item gives exactly one result item, in order.
// pipeline and throughput
//   five register stages: fold, square, sum, pair compare, final select.
//   one item per cycle is taken when the output is not stalled.
// reset and stall
//   i_rst_n (synchronous, active low) clears all stage valid bits; the block
//   keeps no other state. when m_axis_tready is low, stages hold their item
//   and empty stages further up keep filling; s_axis_tready drops only once
//   every stage is occupied.
module lattice_code_point_decoder
    import lcpd_pkg::*;
#(
    parameter int LOG_Q = LOG_Q_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // coord_x, coord_y
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata    // decoded_bits, zero pad
);

    localparam int SQW = 2 * (LOG_Q - 1);
    localparam int SUMW = SQW + 1;

    logic [LOG_Q-1:0] c_tx;
    logic [LOG_Q-1:0] c_ty;

    logic r_v1, r_v2, r_v3, r_v4, r_vo;
    logic c_adv1, c_adv2, c_adv3, c_adv4, c_advo;
    t_axis_en c_axis_en;

    logic [SQW-1:0] c_sqx [3];
    logic [SQW-1:0] c_sqy [3];
    logic c_ox0, c_ox1, c_oy0, c_oy1;

    logic [SUMW-1:0] r_dist [4];
    logic [3:0]      r_outer_s3;
    logic [SUMW-1:0] r_dist_a;
    logic [SUMW-1:0] r_dist_b;
    logic            r_sel_a;
    logic            r_sel_b;
    logic [3:0]      r_outer_s4;
    logic [OUT_W-1:0] r_bits;

    logic            c_pick_b;
    logic [1:0]      c_best;
    logic [OUT_W-1:0] n_bits;

    // stage advance: a stage loads when empty or when the next one loads
    assign c_advo = !r_vo || m_axis_tready;
    assign c_adv4 = !r_v4 || c_advo;
    assign c_adv3 = !r_v3 || c_adv4;
    assign c_adv2 = !r_v2 || c_adv3;
    assign c_adv1 = !r_v1 || c_adv2;
    assign s_axis_tready = c_adv1;

    assign c_axis_en.s1 = c_adv1;
    assign c_axis_en.s2 = c_adv2;

    // unpack coordinates, keep low LOG_Q bits
    assign c_tx = s_axis_tdata[LOG_Q-1:0];
    assign c_ty = s_axis_tdata[COORD_W+LOG_Q-1:COORD_W];

    // stages 1 and 2 for each coordinate
    lcpd_axis #(
        .LOG_Q (LOG_Q)
    ) u_axis_x (
        .i_clk      (i_clk),
        .i_en       (c_axis_en),
        .i_coord    (c_tx),
        .o_sq_zero  (c_sqx[0]),
        .o_sq_plus  (c_sqx[1]),
        .o_sq_minus (c_sqx[2]),
        .o_outer0   (c_ox0),
        .o_outer1   (c_ox1)
    );

    lcpd_axis #(
        .LOG_Q (LOG_Q)
    ) u_axis_y (
        .i_clk      (i_clk),
        .i_en       (c_axis_en),
        .i_coord    (c_ty),
        .o_sq_zero  (c_sqy[0]),
        .o_sq_plus  (c_sqy[1]),
        .o_sq_minus (c_sqy[2]),
        .o_outer0   (c_oy0),
        .o_outer1   (c_oy1)
    );

    // valid bits travel with the items
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (c_adv1) r_v1 <= s_axis_tvalid;
            if (c_adv2) r_v2 <= r_v1;
            if (c_adv3) r_v3 <= r_v2;
            if (c_adv4) r_v4 <= r_v3;
            if (c_advo) r_vo <= r_v4;
        end
    end

    // stage 3: squared distance to each inner codeword
    always_ff @(posedge i_clk) begin
        if (c_adv3) begin
            r_dist[0]  <= SUMW'(c_sqx[0]) + SUMW'(c_sqy[0]);
            r_dist[1]  <= SUMW'(c_sqx[0]) + SUMW'(c_sqy[1]);
            r_dist[2]  <= SUMW'(c_sqx[1]) + SUMW'(c_sqy[0]);
            r_dist[3]  <= SUMW'(c_sqx[2]) + SUMW'(c_sqy[2]);
            r_outer_s3 <= {c_ox1, c_ox0, c_oy1, c_oy0};
        end
    end

    // stage 4: pairwise minimum, ties keep the lower index
    always_ff @(posedge i_clk) begin
        if (c_adv4) begin
            r_sel_a    <= r_dist[1] < r_dist[0];
            r_sel_b    <= r_dist[3] < r_dist[2];
            r_dist_a   <= (r_dist[1] < r_dist[0]) ? r_dist[1] : r_dist[0];
            r_dist_b   <= (r_dist[3] < r_dist[2]) ? r_dist[3] : r_dist[2];
            r_outer_s4 <= r_outer_s3;
        end
    end

    // final select of the inner index and the matching outer bits
    always_comb begin
        c_pick_b = r_dist_b < r_dist_a;
        c_best   = c_pick_b ? {1'b1, r_sel_b} : {1'b0, r_sel_a};
        n_bits   = {c_best[1] ? r_outer_s4[3] : r_outer_s4[2],
                    c_best[0] ? r_outer_s4[1] : r_outer_s4[0],
                    c_best};
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (c_advo) begin
            r_bits <= n_bits;
        end
    end

    assign m_axis_tvalid = r_vo;
    assign m_axis_tdata  = {{(OUT_TDATA_W - OUT_W){1'b0}}, r_bits};

endmodule

// ===== hdl/lcpd_axis.sv =====
// per-coordinate front end: folded distances to the three codeword offsets,
// their squares, and the two outer-bit candidates; two register stages
// depends on lcpd_pkg
module lcpd_axis
    import lcpd_pkg::*;
#(
    parameter int LOG_Q = LOG_Q_DEF
) (
    input  logic                      i_clk,
    input  t_axis_en                  i_en,
    input  logic [LOG_Q-1:0]          i_coord,
    output logic [2*(LOG_Q-1)-1:0]    o_sq_zero,   // offset 0
    output logic [2*(LOG_Q-1)-1:0]    o_sq_plus,   // offset +q/4
    output logic [2*(LOG_Q-1)-1:0]    o_sq_minus,  // offset -q/4
    output logic                      o_outer0,    // outer bit when inner bit is 0
    output logic                      o_outer1     // outer bit when inner bit is 1
);

    localparam int DW  = LOG_Q - 1;
    localparam int SQW = 2 * DW;

    localparam logic [LOG_Q-1:0] Q_HALF    = LOG_Q'(1) << (LOG_Q - 1);
    localparam logic [LOG_Q-1:0] Q_QUARTER = LOG_Q'(1) << (LOG_Q - 2);
    localparam logic [LOG_Q-1:0] Q_3QUART  = LOG_Q'(3) << (LOG_Q - 2);

    logic signed [LOG_Q:0] c_ctr;
    logic signed [LOG_Q:0] c_diff [3];
    logic [LOG_Q-1:0]      c_mag  [3];
    logic [DW-1:0]         c_fold [3];

    logic [DW-1:0]  r_fold [3];
    logic           r_outer0_s1;
    logic           r_outer1_s1;
    logic [SQW-1:0] r_sq   [3];
    logic           r_outer0_s2;
    logic           r_outer1_s2;

    // center the coordinate and fold each difference modulo q/2
    always_comb begin
        c_ctr     = $signed({1'b0, i_coord}) - $signed({1'b0, Q_HALF});
        c_diff[0] = c_ctr;
        c_diff[1] = c_ctr - $signed({1'b0, Q_QUARTER});
        c_diff[2] = c_ctr + $signed({1'b0, Q_QUARTER});
        for (int k = 0; k < 3; k++) begin
            if (c_diff[k] < 0) begin
                c_mag[k] = LOG_Q'(-c_diff[k]);
            end else begin
                c_mag[k] = LOG_Q'(c_diff[k]);
            end
            if (c_mag[k] > Q_QUARTER) begin
                if (c_mag[k] >= Q_HALF) begin
                    c_fold[k] = DW'(c_mag[k] - Q_HALF);
                end else begin
                    c_fold[k] = DW'(Q_HALF - c_mag[k]);
                end
            end else begin
                c_fold[k] = DW'(c_mag[k]);
            end
        end
    end

    // stage 1: folded magnitudes and outer-bit candidates
    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r_fold      <= c_fold;
            r_outer0_s1 <= (i_coord > Q_QUARTER) && (i_coord < Q_3QUART);
            r_outer1_s1 <= i_coord > Q_HALF;
        end
    end

    // stage 2: squares
    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            for (int k = 0; k < 3; k++) begin
                r_sq[k] <= SQW'(r_fold[k]) * SQW'(r_fold[k]);
            end
            r_outer0_s2 <= r_outer0_s1;
            r_outer1_s2 <= r_outer1_s1;
        end
    end

    assign o_sq_zero  = r_sq[0];
    assign o_sq_plus  = r_sq[1];
    assign o_sq_minus = r_sq[2];
    assign o_outer0   = r_outer0_s2;
    assign o_outer1   = r_outer1_s2;

endmodule
